/* design/aptd_pkg.sv */
// shared types and constants for the axle pulse train detector
package aptd_pkg;

    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned TALLY_W = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SENSOR_HOLD = 3'd0,
        REG_WINDOW      = 3'd1,
        REG_EDGES       = 3'd2,
        REG_LED_HOLD    = 3'd3,
        REG_COOLDOWN    = 3'd4
    } cfg_idx_t;

    localparam logic [31:0] SENSOR_HOLD_RST = 32'd60000;
    localparam logic [31:0] WINDOW_RST = 32'd10000;
    localparam logic [TALLY_W-1:0] EDGES_RST = 4'd8;
    localparam logic [31:0] LED_HOLD_RST = 32'd30000;
    localparam logic [31:0] COOLDOWN_RST = 32'd180000;

    typedef struct packed {
        logic [31:0]        sensor_hold_ms;
        logic [31:0]        window_ms;
        logic [TALLY_W-1:0] edges_needed;
        logic [31:0]        led_hold_ms;
        logic [31:0]        cooldown_ms;
    } cfg_t;

    typedef struct packed {
        logic        button_level;
        logic        sensor_level;
        logic [31:0] now_ms;
    } item_t;

    typedef struct packed {
        logic [TALLY_W-1:0] edge_tally;
        logic               cooldown_on;
        logic               test_report;
        logic               train_report;
        logic               indicator_on;
        logic               sensor_ok;
    } result_t;

    localparam int unsigned IN_TDATA_W = 40;
    localparam int unsigned OUT_TDATA_W = 16;

endpackage

/* design/aptd_engine.sv */
// detector state and the per-sample step logic
module aptd_engine #(
    parameter int unsigned TIME_WIDTH = 32
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             step_en,
    input  aptd_pkg::item_t  item,
    input  aptd_pkg::cfg_t   cfg,
    output aptd_pkg::result_t result
);

    localparam int unsigned CMP_W = (TIME_WIDTH > 32) ? TIME_WIDTH : 32;

    typedef logic [TIME_WIDTH-1:0] stamp_t;

    logic                         status_reg, status_next;
    logic                         last_level_reg, last_level_next;
    stamp_t                       low_since_reg, low_since_next;
    logic                         low_valid_reg, low_valid_next;
    stamp_t                       win_start_reg, win_start_next;
    logic                         win_valid_reg, win_valid_next;
    logic [aptd_pkg::TALLY_W-1:0] count_reg, count_next;
    stamp_t                       lamp_since_reg, lamp_since_next;
    logic                         lamp_valid_reg, lamp_valid_next;
    stamp_t                       cool_since_reg, cool_since_next;
    logic                         cool_valid_reg, cool_valid_next;

    stamp_t                       now;
    stamp_t                       low_el, win_el, lamp_el, cool_el;
    logic                         pressed, lamp_start, edge_seen, count_ok, train;
    logic                         win_open;
    logic                         lamp_on, cool_on;
    logic [aptd_pkg::TALLY_W-1:0] count_inc;

    always_comb begin
        now = stamp_t'(item.now_ms);
        pressed = !item.button_level;

        // test button
        lamp_start = pressed && !lamp_valid_reg;
        lamp_since_next = lamp_start ? now : lamp_since_reg;
        lamp_on = lamp_valid_reg || lamp_start;

        // sensor status with low hold
        status_next = status_reg;
        low_since_next = low_since_reg;
        low_valid_next = low_valid_reg;
        if (item.sensor_level) begin
            low_valid_next = 1'b0;
            status_next = 1'b1;
        end else begin
            if (!low_valid_reg) begin
                low_since_next = now;
            end
            low_valid_next = 1'b1;
        end
        low_el = now - low_since_next;
        if (!item.sensor_level && (CMP_W'(low_el) > CMP_W'(cfg.sensor_hold_ms))) begin
            status_next = 1'b0;
        end

        // edge counting
        edge_seen = item.sensor_level != last_level_reg;
        last_level_next = item.sensor_level;
        win_start_next = (edge_seen && !win_valid_reg) ? now : win_start_reg;
        win_open = win_valid_reg || edge_seen;
        win_el = now - win_start_next;
        count_inc = count_reg + 1'b1;
        count_ok = edge_seen && !cool_valid_reg
                   && (CMP_W'(win_el) < CMP_W'(cfg.window_ms));
        train = count_ok && (count_inc >= cfg.edges_needed);

        count_next = count_reg;
        if (count_ok) begin
            count_next = train ? '0 : count_inc;
        end
        cool_since_next = cool_since_reg;
        cool_on = cool_valid_reg;
        if (train) begin
            win_open = 1'b0;
            cool_since_next = now;
            cool_on = 1'b1;
            lamp_since_next = now;
            lamp_on = 1'b1;
        end

        // window lapse
        win_valid_next = win_open;
        if (win_open && (CMP_W'(win_el) > CMP_W'(cfg.window_ms))) begin
            count_next = '0;
            win_valid_next = 1'b0;
        end

        // indicator and cooldown timeouts
        lamp_el = now - lamp_since_next;
        lamp_valid_next = lamp_on && !(CMP_W'(lamp_el) > CMP_W'(cfg.led_hold_ms));
        cool_el = now - cool_since_next;
        cool_valid_next = cool_on && !(CMP_W'(cool_el) > CMP_W'(cfg.cooldown_ms));

        result.sensor_ok = status_next;
        result.indicator_on = lamp_valid_next;
        result.train_report = train;
        result.test_report = lamp_start;
        result.cooldown_on = cool_valid_next;
        result.edge_tally = count_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            status_reg <= 1'b0;
            last_level_reg <= 1'b0;
            low_valid_reg <= 1'b0;
            win_valid_reg <= 1'b0;
            count_reg <= '0;
            lamp_valid_reg <= 1'b0;
            cool_valid_reg <= 1'b0;
        end else if (step_en) begin
            status_reg <= status_next;
            last_level_reg <= last_level_next;
            low_valid_reg <= low_valid_next;
            win_valid_reg <= win_valid_next;
            count_reg <= count_next;
            lamp_valid_reg <= lamp_valid_next;
            cool_valid_reg <= cool_valid_next;
        end
    end

    // timestamps are only read while their valid flag is set
    always_ff @(posedge aclk) begin
        if (step_en) begin
            low_since_reg <= low_since_next;
            win_start_reg <= win_start_next;
            lamp_since_reg <= lamp_since_next;
            cool_since_reg <= cool_since_next;
        end
    end

    a_no_count_in_cooldown: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en && cool_valid_reg |-> !result.train_report)
        else $error("train reported while cooldown running");

    a_closed_window_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !win_valid_reg |-> count_reg == '0)
        else $error("edge count held with no open window");

    a_train_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en && result.train_report |=> !win_valid_reg && cool_valid_reg)
        else $error("train did not close window and start cooldown");

endmodule

/* design/axle_pulse_train_detector.sv */
// top level of the axle pulse train detector with stream and config ports
//
// One sample item is taken per clock cycle while s_tready is high, and each gives
// exactly one result item. An accepted item sits in an input register until it
// advances, the step logic updates the detector state from it as it advances and
// the result lands in an output register. The throughput is one item per cycle
// while the result side keeps taking items. That rate is set by the state update
// in aptd_engine, which takes one step per item: every sample sees the state
// left by the sample before it. Configuration writes are taken at any time on
// their own channel and must only be issued while the block holds no item.
module axle_pulse_train_detector #(
    parameter int unsigned TIME_WIDTH = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // now_ms[31:0], sensor_level[32], button_level[33], zero pad[39:34]
    input  logic [aptd_pkg::IN_TDATA_W-1:0]     s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // sensor_ok[0], indicator_on[1], train_report[2], test_report[3],
    // cooldown_on[4], edge_tally[8:5], zero pad[15:9]
    output logic [aptd_pkg::OUT_TDATA_W-1:0]    m_tdata,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [aptd_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  logic [aptd_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    localparam int unsigned ITEM_W = $bits(aptd_pkg::item_t);
    localparam int unsigned RES_W = $bits(aptd_pkg::result_t);

    aptd_pkg::cfg_t    cfg_reg;
    aptd_pkg::item_t   item_reg;
    logic              in_valid_reg;
    aptd_pkg::result_t result_reg;
    aptd_pkg::result_t step_result;
    logic              out_valid_reg;
    logic              advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign m_tvalid = out_valid_reg;
    assign m_tdata = {(aptd_pkg::OUT_TDATA_W - RES_W)'(0), result_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sensor_hold_ms <= aptd_pkg::SENSOR_HOLD_RST;
            cfg_reg.window_ms <= aptd_pkg::WINDOW_RST;
            cfg_reg.edges_needed <= aptd_pkg::EDGES_RST;
            cfg_reg.led_hold_ms <= aptd_pkg::LED_HOLD_RST;
            cfg_reg.cooldown_ms <= aptd_pkg::COOLDOWN_RST;
        end else if (cfg_valid) begin
            unique case (aptd_pkg::cfg_idx_t'(cfg_addr))
                aptd_pkg::REG_SENSOR_HOLD: cfg_reg.sensor_hold_ms <= cfg_wdata;
                aptd_pkg::REG_WINDOW:      cfg_reg.window_ms <= cfg_wdata;
                aptd_pkg::REG_EDGES: begin
                    cfg_reg.edges_needed <= cfg_wdata[aptd_pkg::TALLY_W-1:0];
                end
                aptd_pkg::REG_LED_HOLD:    cfg_reg.led_hold_ms <= cfg_wdata;
                aptd_pkg::REG_COOLDOWN:    cfg_reg.cooldown_ms <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg <= aptd_pkg::item_t'(s_tdata[ITEM_W-1:0]);
        end
        if (advance) begin
            result_reg <= step_result;
        end
    end

    aptd_engine #(
        .TIME_WIDTH(TIME_WIDTH)
    ) u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (advance),
        .item    (item_reg),
        .cfg     (cfg_reg),
        .result  (step_result)
    );

    a_train_lights: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && result_reg.train_report |->
            result_reg.cooldown_on && result_reg.indicator_on
            && result_reg.edge_tally == '0)
        else $error("train item without indicator, cooldown or cleared tally");

    a_test_lights: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && result_reg.test_report |-> result_reg.indicator_on)
        else $error("test item with dark indicator");

    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_tvalid)
        else $error("stepped item produced no result");

endmodule

/* bench/aptd_train_checker.sv */
// predicts and checks the result items of the axle pulse train detector
module aptd_train_checker (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    // now_ms[31:0], sensor_level[32], button_level[33], zero pad[39:34]
    input  logic [aptd_pkg::IN_TDATA_W-1:0]  s_tdata,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    // sensor_ok[0], indicator_on[1], train_report[2], test_report[3],
    // cooldown_on[4], edge_tally[8:5], zero pad[15:9]
    input  logic [aptd_pkg::OUT_TDATA_W-1:0] m_tdata,
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [aptd_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  logic [aptd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output int                               mismatch_count,
    output int                               reports_owed
);

    localparam int unsigned RES_W = $bits(aptd_pkg::result_t);
    localparam int unsigned ITEM_W = $bits(aptd_pkg::item_t);

    // register copy
    logic [31:0]                  hold_len;
    logic [31:0]                  window_len;
    logic [aptd_pkg::TALLY_W-1:0] edges_goal;
    logic [31:0]                  lamp_len;
    logic [31:0]                  cool_len;

    // detector state copy
    logic                         status_q;
    logic                         prev_level;
    logic [31:0]                  low_t;
    logic                         low_ok;
    logic [31:0]                  win_t;
    logic                         win_ok;
    logic [aptd_pkg::TALLY_W-1:0] tally;
    logic [31:0]                  lamp_t;
    logic                         lamp_ok;
    logic [31:0]                  cool_t;
    logic                         cool_ok;

    aptd_pkg::result_t pending_reports[$];

    function automatic aptd_pkg::result_t step_detector(input aptd_pkg::item_t smp);
        logic [31:0]       now;
        logic [31:0]       since_low;
        logic [31:0]       since_win;
        logic              lvl;
        logic              pressed;
        logic              train;
        logic              test;
        aptd_pkg::result_t r;
        now = smp.now_ms;
        lvl = smp.sensor_level;
        pressed = !smp.button_level;
        train = 1'b0;
        test = 1'b0;

        if (pressed && !lamp_ok) begin
            lamp_ok = 1'b1;
            lamp_t = now;
            test = 1'b1;
        end

        if (lvl) begin
            low_ok = 1'b0;
            status_q = 1'b1;
        end else begin
            if (!low_ok) begin
                low_t = now;
                low_ok = 1'b1;
            end
            since_low = now - low_t;
            if (since_low > hold_len) status_q = 1'b0;
        end

        if (lvl != prev_level) begin
            if (!win_ok) begin
                win_t = now;
                win_ok = 1'b1;
            end
            prev_level = lvl;
            since_win = now - win_t;
            if (since_win < window_len && !cool_ok) begin
                tally = tally + 1'b1;
                if (tally >= edges_goal) begin
                    train = 1'b1;
                    tally = '0;
                    win_ok = 1'b0;
                    cool_t = now;
                    cool_ok = 1'b1;
                    lamp_t = now;
                    lamp_ok = 1'b1;
                end
            end
        end

        since_win = now - win_t;
        if (win_ok && since_win > window_len) begin
            tally = '0;
            win_ok = 1'b0;
        end
        if (lamp_ok && (now - lamp_t) > lamp_len) lamp_ok = 1'b0;
        if (cool_ok && (now - cool_t) > cool_len) cool_ok = 1'b0;

        r.sensor_ok = status_q;
        r.indicator_on = lamp_ok;
        r.train_report = train;
        r.test_report = test;
        r.cooldown_on = cool_ok;
        r.edge_tally = tally;
        return r;
    endfunction

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge aclk) begin
        aptd_pkg::result_t got;
        aptd_pkg::result_t want;
        if (!aresetn) begin
            hold_len = aptd_pkg::SENSOR_HOLD_RST;
            window_len = aptd_pkg::WINDOW_RST;
            edges_goal = aptd_pkg::EDGES_RST;
            lamp_len = aptd_pkg::LED_HOLD_RST;
            cool_len = aptd_pkg::COOLDOWN_RST;
            status_q = 1'b0;
            prev_level = 1'b0;
            low_t = '0;
            low_ok = 1'b0;
            win_t = '0;
            win_ok = 1'b0;
            tally = '0;
            lamp_t = '0;
            lamp_ok = 1'b0;
            cool_t = '0;
            cool_ok = 1'b0;
            mismatch_count = 0;
            pending_reports.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got = aptd_pkg::result_t'(m_tdata[RES_W-1:0]);
                if (pending_reports.size() == 0) begin
                    $display("%0t: no item waiting, expected none actual %0h",
                             $time, m_tdata);
                    mismatch_count++;
                end else begin
                    want = pending_reports.pop_front();
                    check_field("sensor_ok", 32'(want.sensor_ok), 32'(got.sensor_ok));
                    check_field("indicator_on", 32'(want.indicator_on),
                                32'(got.indicator_on));
                    check_field("train_report", 32'(want.train_report),
                                32'(got.train_report));
                    check_field("test_report", 32'(want.test_report),
                                32'(got.test_report));
                    check_field("cooldown_on", 32'(want.cooldown_on),
                                32'(got.cooldown_on));
                    check_field("edge_tally", 32'(want.edge_tally), 32'(got.edge_tally));
                    check_field("pad", '0, 32'(m_tdata[aptd_pkg::OUT_TDATA_W-1:RES_W]));
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (aptd_pkg::cfg_idx_t'(cfg_addr))
                    aptd_pkg::REG_SENSOR_HOLD: hold_len = cfg_wdata;
                    aptd_pkg::REG_WINDOW:      window_len = cfg_wdata;
                    aptd_pkg::REG_EDGES:       edges_goal = cfg_wdata[aptd_pkg::TALLY_W-1:0];
                    aptd_pkg::REG_LED_HOLD:    lamp_len = cfg_wdata;
                    aptd_pkg::REG_COOLDOWN:    cool_len = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                pending_reports.push_back(
                    step_detector(aptd_pkg::item_t'(s_tdata[ITEM_W-1:0])));
        end
        reports_owed = pending_reports.size();
    end

endmodule

/* bench/tb_axle_pulse_train_detector.sv */
// stimulus and verdict for the axle pulse train detector
module tb_axle_pulse_train_detector;

    logic                             aclk;
    logic                             aresetn;
    logic                             s_tvalid;
    logic                             s_tready;
    logic [aptd_pkg::IN_TDATA_W-1:0]  s_tdata;
    logic                             m_tvalid;
    logic                             m_tready;
    logic [aptd_pkg::OUT_TDATA_W-1:0] m_tdata;
    logic                             cfg_valid;
    logic                             cfg_ready;
    logic [aptd_pkg::CFG_IDX_W-1:0]   cfg_addr;
    logic [aptd_pkg::CFG_DATA_W-1:0]  cfg_wdata;

    int mismatch_count;
    int reports_owed;

    logic [31:0] clock_ms;
    logic        lvl;
    int          gap_odds;
    int          stall_odds;
    logic        quiet;

    axle_pulse_train_detector dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    aptd_train_checker checker_i (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .mismatch_count (mismatch_count),
        .reports_owed   (reports_owed)
    );

    always begin
        aclk = 1'b1;
        #2;
        aclk = 1'b0;
        #2;
    end

    initial begin
        #2000000;
        $display("Mismatches found");
        $finish;
    end

    // result side backpressure
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (!quiet && stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(negedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    // every task starts and ends at a falling edge with nothing yet driven there
    task automatic send_sample(input logic [31:0] t, input logic level,
                               input logic btn);
        aptd_pkg::item_t smp;
        smp.now_ms = t;
        smp.sensor_level = level;
        smp.button_level = btn;
        if (!quiet && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {{(aptd_pkg::IN_TDATA_W - $bits(aptd_pkg::item_t)){1'b0}}, smp};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (reports_owed != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_reg(input aptd_pkg::cfg_idx_t idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic apply_setup(input logic [31:0] hold, input logic [31:0] win,
                               input logic [3:0] goal, input logic [31:0] lamp,
                               input logic [31:0] cool);
        settle();
        write_reg(aptd_pkg::REG_SENSOR_HOLD, hold);
        write_reg(aptd_pkg::REG_WINDOW, win);
        write_reg(aptd_pkg::REG_EDGES, {28'd0, goal});
        write_reg(aptd_pkg::REG_LED_HOLD, lamp);
        write_reg(aptd_pkg::REG_COOLDOWN, cool);
    endtask

    // mostly toggle bursts that can make trains, with steady runs and jumps
    task automatic wander(input int count, input int unsigned step_max);
        int sent;
        int len;
        int kind;
        sent = 0;
        while (sent < count) begin
            kind = $urandom_range(0, 9);
            if (kind < 6) begin
                len = $urandom_range(1, 18);
                repeat (len) begin
                    clock_ms = clock_ms + $urandom_range(0, step_max);
                    lvl = ~lvl;
                    send_sample(clock_ms, lvl, $urandom_range(0, 7) != 0);
                end
            end else if (kind < 8) begin
                len = $urandom_range(1, 6);
                repeat (len) begin
                    clock_ms = clock_ms + $urandom_range(0, 4 * step_max);
                    send_sample(clock_ms, lvl, $urandom_range(0, 3) != 0);
                end
            end else begin
                len = 1;
                if (kind == 8)
                    clock_ms = $urandom;
                else
                    clock_ms = clock_ms + $urandom_range(0, 50 * step_max);
                lvl = 1'($urandom_range(0, 1));
                send_sample(clock_ms, lvl, 1'($urandom_range(0, 1)));
            end
            sent += len;
        end
    endtask

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_valid = 1'b0;
        cfg_addr = aptd_pkg::REG_SENSOR_HOLD;
        cfg_wdata = '0;
        quiet = 1'b0;
        gap_odds = 4;
        stall_odds = 4;
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset settings: time zero, a full train, lamp and cooldown lapse, wrap
        send_sample(32'd0, 1'b0, 1'b0);
        send_sample(32'd0, 1'b1, 1'b1);
        send_sample(32'd1, 1'b0, 1'b1);
        send_sample(32'd2, 1'b1, 1'b1);
        send_sample(32'd3, 1'b0, 1'b1);
        send_sample(32'd4, 1'b1, 1'b1);
        send_sample(32'd5, 1'b0, 1'b1);
        send_sample(32'd6, 1'b1, 1'b1);
        send_sample(32'd7, 1'b0, 1'b1);
        send_sample(32'd8, 1'b1, 1'b0);
        send_sample(32'd30009, 1'b1, 1'b1);
        send_sample(32'd30010, 1'b1, 1'b0);
        send_sample(32'd200000, 1'b0, 1'b1);
        send_sample(32'd260000, 1'b0, 1'b1);
        send_sample(32'd260001, 1'b0, 1'b1);
        send_sample(32'hFFFF_FFF0, 1'b1, 1'b1);
        send_sample(32'hFFFF_FFFF, 1'b0, 1'b1);
        send_sample(32'h0000_0004, 1'b1, 1'b1);
        send_sample(32'h0000_0010, 1'b0, 1'b0);
        clock_ms = 32'h0000_0010;
        lvl = 1'b0;
        wander(50, 2000);

        gap_odds = 3;
        stall_odds = 3;
        apply_setup(32'd20, 32'd50, 4'd3, 32'd30, 32'd100);
        wander(70, 12);

        // zero hold times and single-edge trains, no idling here
        gap_odds = 0;
        stall_odds = 0;
        apply_setup(32'd0, 32'd5, 4'd1, 32'd0, 32'd0);
        wander(60, 3);

        // zero window: nothing is ever counted
        gap_odds = 5;
        stall_odds = 2;
        apply_setup(32'd10, 32'd0, 4'd2, 32'd10, 32'd10);
        wander(50, 6);

        gap_odds = 2;
        stall_odds = 5;
        apply_setup(32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        wander(60, 1000);

        // zero edge goal: the first counted edge is a train
        gap_odds = 4;
        stall_odds = 4;
        apply_setup(32'd5, 32'd30, 4'd0, 32'd20, 32'd40);
        wander(60, 6);

        apply_setup($urandom_range(0, 300), $urandom_range(1, 300),
                    4'($urandom_range(1, 15)), $urandom_range(0, 300),
                    $urandom_range(0, 300));
        wander(70, 40);

        gap_odds = 3;
        stall_odds = 3;
        apply_setup($urandom, $urandom, 4'($urandom_range(0, 15)), $urandom, $urandom);
        wander(40, 1 << 24);
        quiet = 1'b1;
        wander(40, 50);

        settle();
        repeat (8) @(negedge aclk);
        if (mismatch_count == 0 && reports_owed == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
